// ===== rtl/core/adv_filter_unique_address_counter_assert.svh =====
// Assertion macros used by the counter's table RTL file.
// Each macro samples on the rising clock edge and is idle while reset is high.
`ifndef ADV_FILTER_UNIQUE_ADDRESS_COUNTER_ASSERT_SVH
`define ADV_FILTER_UNIQUE_ADDRESS_COUNTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AUC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AUC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/auc_pkg.sv =====
`default_nettype none

package auc_pkg;

   // Fixed field widths.
   localparam int ADDR_W      = 48;
   localparam int BYTE_W      = 8;
   localparam int COMPANY_W   = 16;
   localparam int INDEX_W     = 7;
   localparam int PACKETS_W   = 16;
   localparam int DEVICES_W   = 8;
   localparam int TOTAL_W     = 32;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   // Advertising structure constants.
   localparam logic [BYTE_W-1:0] MFG_TYPE        = 8'hFF;
   localparam logic [BYTE_W-1:0] MIN_MFG_LEN     = 8'd3;
   localparam logic [BYTE_W-1:0] MIN_SUBTYPE_LEN = 8'd4;

   // Register reset values.
   localparam logic [COMPANY_W-1:0] RESET_COMPANY = 16'h004C;
   localparam logic [BYTE_W-1:0]    RESET_SUBTYPE = 8'd9;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_COMPANY = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_SUBTYPE = 1'd1;

   // Table sequencer states.
   typedef enum logic [2:0] {
      TBL_IDLE,
      TBL_READ,
      TBL_CMP,
      TBL_HIT,
      TBL_MISS
   } tbl_state_type;

   // Report flags after the current byte has been scanned.
   typedef struct packed {
      logic company_found;
      logic subtype_ok;
   } scan_flags_type;

   // Status and result of the address table.
   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic                 new_device;
      logic                 table_full;
      logic [INDEX_W-1:0]   entry_index;
      logic [PACKETS_W-1:0] entry_packets;
      logic [DEVICES_W-1:0] unique_devices;
   } tbl_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/auc_scan.sv =====
`default_nettype none

module auc_scan
   import auc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 byte_valid,
   input  wire logic [BYTE_W-1:0]    data_byte,
   input  wire logic                 byte_last,
   input  wire logic [COMPANY_W-1:0] target_company,
   input  wire logic [BYTE_W-1:0]    target_subtype,
   output scan_flags_type            flags
);

   logic [BYTE_W-1:0] byte_offset_ff, byte_offset_in;
   logic [BYTE_W-1:0] structure_start_ff, structure_start_in;
   logic [BYTE_W-1:0] structure_length_ff, structure_length_in;
   logic [BYTE_W-1:0] structure_type_ff, structure_type_in;
   logic [BYTE_W-1:0] company_low_ff, company_low_in;
   logic              company_found_ff, company_found_in;
   logic              subtype_ok_ff, subtype_ok_in;

   logic [BYTE_W-1:0] rel;
   logic [BYTE_W-1:0] sc_start;
   logic [BYTE_W-1:0] sc_length;
   logic [BYTE_W-1:0] sc_type;
   logic [BYTE_W-1:0] sc_low;
   logic              sc_found;
   logic              sc_subtype;
   logic              company_hit;

   assign rel         = byte_offset_ff - structure_start_ff;
   assign company_hit = ({data_byte, company_low_ff} == target_company);

   // Walk the length/type structures one byte at a time.
   always_comb begin
      sc_start   = structure_start_ff;
      sc_length  = structure_length_ff;
      sc_type    = structure_type_ff;
      sc_low     = company_low_ff;
      sc_found   = company_found_ff;
      sc_subtype = subtype_ok_ff;
      if (rel == '0) begin
         // Length byte; an empty structure ends right here.
         sc_length = data_byte;
         sc_type   = '0;
         if (data_byte == '0) begin
            sc_start = structure_start_ff + 8'd1;
         end
      end else begin
         if (rel == 8'd1) begin
            sc_type = data_byte;
         end else if (rel == 8'd2) begin
            sc_low = data_byte;
         end else if (rel == 8'd3) begin
            if (structure_type_ff == MFG_TYPE && structure_length_ff >= MIN_MFG_LEN
                && company_hit) begin
               sc_found   = 1'b1;
               sc_subtype = 1'b0;
            end else begin
               // Clear the type so the subtype byte is not checked.
               sc_type = '0;
            end
         end else if (rel == 8'd4) begin
            if (structure_type_ff == MFG_TYPE && structure_length_ff >= MIN_SUBTYPE_LEN) begin
               sc_subtype = (data_byte == target_subtype);
            end
         end
         if (rel == structure_length_ff) begin
            sc_start = structure_start_ff + structure_length_ff + 8'd1;
         end
      end
   end

   assign flags.company_found = sc_found;
   assign flags.subtype_ok    = sc_subtype;

   // The final byte of a report clears the scan state for the next report.
   always_comb begin
      byte_offset_in      = byte_offset_ff;
      structure_start_in  = structure_start_ff;
      structure_length_in = structure_length_ff;
      structure_type_in   = structure_type_ff;
      company_low_in      = company_low_ff;
      company_found_in    = company_found_ff;
      subtype_ok_in       = subtype_ok_ff;
      if (byte_valid) begin
         if (byte_last) begin
            byte_offset_in      = '0;
            structure_start_in  = '0;
            structure_length_in = '0;
            structure_type_in   = '0;
            company_low_in      = '0;
            company_found_in    = 1'b0;
            subtype_ok_in       = 1'b0;
         end else begin
            byte_offset_in      = byte_offset_ff + 8'd1;
            structure_start_in  = sc_start;
            structure_length_in = sc_length;
            structure_type_in   = sc_type;
            company_low_in      = sc_low;
            company_found_in    = sc_found;
            subtype_ok_in       = sc_subtype;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_offset_ff      <= '0;
         structure_start_ff  <= '0;
         structure_length_ff <= '0;
         structure_type_ff   <= '0;
         company_low_ff      <= '0;
         company_found_ff    <= 1'b0;
         subtype_ok_ff       <= 1'b0;
      end else begin
         byte_offset_ff      <= byte_offset_in;
         structure_start_ff  <= structure_start_in;
         structure_length_ff <= structure_length_in;
         structure_type_ff   <= structure_type_in;
         company_low_ff      <= company_low_in;
         company_found_ff    <= company_found_in;
         subtype_ok_ff       <= subtype_ok_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/auc_table.sv =====
`default_nettype none

`include "adv_filter_unique_address_counter_assert.svh"

module auc_table
   import auc_pkg::*;
#(
   parameter int TABLE_ENTRIES = 128,
   parameter int COUNT_WIDTH   = 16
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              go,
   input  wire logic [ADDR_W-1:0] key,
   output tbl_status_type         status
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   typedef struct packed {
      logic [ADDR_W-1:0]      addr;
      logic [COUNT_WIDTH-1:0] count;
   } entry_type;

   // Address and packet count storage, one entry per slot.
   entry_type entry_mem_ff [TABLE_ENTRIES];
   entry_type rd_data_ff;

   tbl_state_type        state_ff, state_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     entry_count_ff, entry_count_in;
   logic [ADDR_W-1:0]    key_ff;
   logic                 done_ff, done_in;
   logic                 res_new_ff, res_new_in;
   logic                 res_full_ff, res_full_in;
   logic [INDEX_W-1:0]   res_idx_ff, res_idx_in;
   logic [PACKETS_W-1:0] res_pk_ff, res_pk_in;

   logic                   rd_en;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   entry_type              mem_wdata;
   logic                   hit;
   logic                   last_entry;
   logic                   room;
   logic [COUNT_WIDTH-1:0] count_next;
   logic [IDX_W-1:0]       fill_idx;
   logic [31:0]            idx_wide;
   logic [31:0]            fill_wide;
   logic [31:0]            pk_wide;
   logic [31:0]            devices_wide;

   // Shared compare unit and the saturating count increment.
   assign hit        = (rd_data_ff.addr == key_ff);
   assign last_entry = ((CNT_W'(idx_ff) + CNT_W'(1)) == entry_count_ff);
   assign room       = (entry_count_ff < CNT_W'(TABLE_ENTRIES));
   assign count_next = (rd_data_ff.count == '1) ? rd_data_ff.count
                                                : rd_data_ff.count + COUNT_WIDTH'(1);
   assign fill_idx   = entry_count_ff[IDX_W-1:0];

   assign idx_wide     = 32'(idx_ff);
   assign fill_wide    = 32'(fill_idx);
   assign pk_wide      = 32'(count_next);
   assign devices_wide = 32'(entry_count_ff);

   // Next state of the search sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         TBL_IDLE: begin
            if (go) begin
               state_in = (entry_count_ff == '0) ? TBL_MISS : TBL_READ;
            end
         end
         TBL_READ: begin
            state_in = TBL_CMP;
         end
         TBL_CMP: begin
            if (hit) begin
               state_in = TBL_HIT;
            end else if (last_entry) begin
               state_in = TBL_MISS;
            end else begin
               state_in = TBL_READ;
            end
         end
         TBL_HIT: begin
            state_in = TBL_IDLE;
         end
         TBL_MISS: begin
            state_in = TBL_IDLE;
         end
         default: begin
            state_in = TBL_IDLE;
         end
      endcase
   end

   // Sequencer outputs: memory strobes, slot pointer and the result word.
   always_comb begin
      idx_in         = idx_ff;
      rd_en          = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = idx_ff;
      mem_wdata      = '{addr: key_ff, count: count_next};
      entry_count_in = entry_count_ff;
      done_in        = 1'b0;
      res_new_in     = res_new_ff;
      res_full_in    = res_full_ff;
      res_idx_in     = res_idx_ff;
      res_pk_in      = res_pk_ff;
      unique case (state_ff)
         TBL_IDLE: begin
            idx_in = '0;
         end
         TBL_READ: begin
            rd_en = 1'b1;
         end
         TBL_CMP: begin
            if (!hit && !last_entry) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         TBL_HIT: begin
            // Known address: store the raised count back in place.
            mem_we      = 1'b1;
            done_in     = 1'b1;
            res_new_in  = 1'b0;
            res_full_in = 1'b0;
            res_idx_in  = idx_wide[INDEX_W-1:0];
            res_pk_in   = pk_wide[PACKETS_W-1:0];
         end
         TBL_MISS: begin
            done_in = 1'b1;
            if (room) begin
               // New address goes into the next free slot with a count of one.
               mem_we         = 1'b1;
               mem_waddr      = fill_idx;
               mem_wdata      = '{addr: key_ff, count: COUNT_WIDTH'(1)};
               entry_count_in = entry_count_ff + CNT_W'(1);
               res_new_in     = 1'b1;
               res_full_in    = 1'b0;
               res_idx_in     = fill_wide[INDEX_W-1:0];
               res_pk_in      = PACKETS_W'(1);
            end else begin
               res_new_in  = 1'b0;
               res_full_in = 1'b1;
               res_idx_in  = '0;
               res_pk_in   = '0;
            end
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= TBL_IDLE;
         entry_count_ff <= '0;
         done_ff        <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         done_ff        <= done_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      res_new_ff  <= res_new_in;
      res_full_ff <= res_full_in;
      res_idx_ff  <= res_idx_in;
      res_pk_ff   <= res_pk_in;
      if (state_ff == TBL_IDLE && go) begin
         key_ff <= key;
      end
   end

   // Table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem_ff[idx_ff];
      end
   end

   assign status.busy           = (state_ff != TBL_IDLE);
   assign status.done           = done_ff;
   assign status.new_device     = res_new_ff;
   assign status.table_full     = res_full_ff;
   assign status.entry_index    = res_idx_ff;
   assign status.entry_packets  = res_pk_ff;
   assign status.unique_devices = devices_wide[DEVICES_W-1:0];

   `AUC_ASSERT_NEXT(a_done_after_update, (state_ff == TBL_HIT || state_ff == TBL_MISS), done_ff, "table result word missing after update")
   `AUC_ASSERT_NEXT(a_miss_outcome, (state_ff == TBL_MISS), (res_new_ff != res_full_ff), "miss must either add the address or flag a full table")
   `AUC_ASSERT_NOW(a_compare_in_range, (state_ff == TBL_CMP), (CNT_W'(idx_ff) < entry_count_ff), "search compared a slot beyond the stored entries")

endmodule

`default_nettype wire

// ===== rtl/core/adv_filter_unique_address_counter.sv =====
// A non-final report byte is scanned as it is accepted and busy stays low.
// A final byte without a subtype match gives its result word in the next cycle.
// A final byte with a subtype match walks the address table: it reads and compares
// the stored addresses in turn until one matches, then updates the table; busy stays high.
// Results cannot be stalled; synchronous reset clears the report total and table fill.
`default_nettype none

module adv_filter_unique_address_counter
   import auc_pkg::*;
#(
   parameter int TABLE_ENTRIES = 128,
   parameter int COUNT_WIDTH   = 16
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic                   req_is_report,
   input  wire logic [ADDR_W-1:0]      req_sender_address,
   input  wire logic [BYTE_W-1:0]      req_data_byte,
   input  wire logic                   req_byte_last,
   output logic                        rsp_strobe,
   output logic                        rsp_company_seen,
   output logic                        rsp_subtype_match,
   output logic                        rsp_new_device,
   output logic                        rsp_table_full,
   output logic [INDEX_W-1:0]          rsp_entry_index,
   output logic [PACKETS_W-1:0]        rsp_entry_packets,
   output logic [DEVICES_W-1:0]        rsp_unique_devices,
   output logic [TOTAL_W-1:0]          rsp_company_reports,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic [COMPANY_W-1:0] target_company_ff, target_company_in;
   logic [BYTE_W-1:0]    target_subtype_ff, target_subtype_in;
   logic [TOTAL_W-1:0]   report_total_ff, report_total_in;
   logic                 direct_ff, direct_in;
   logic                 seen_ff;
   logic                 sub_ff;

   logic           accept;
   logic           byte_valid;
   logic           report_end;
   logic           table_go;
   scan_flags_type flags;
   tbl_status_type tbl_status;

   assign busy       = tbl_status.busy;
   assign accept     = start && !busy;
   assign byte_valid = accept && req_is_report;
   assign report_end = byte_valid && req_byte_last;
   assign table_go   = report_end && flags.subtype_ok;

   // Configuration registers.
   always_comb begin
      target_company_in = target_company_ff;
      target_subtype_in = target_subtype_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TARGET_COMPANY: target_company_in = csr_write_data;
            CSR_TARGET_SUBTYPE: target_subtype_in = csr_write_data[BYTE_W-1:0];
            default:            target_company_in = target_company_ff;
         endcase
      end
   end

   // Saturating total of reports that carried the company, and the direct result.
   always_comb begin
      report_total_in = report_total_ff;
      if (report_end && flags.company_found && report_total_ff != '1) begin
         report_total_in = report_total_ff + TOTAL_W'(1);
      end
      direct_in = report_end && !flags.subtype_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_company_ff <= RESET_COMPANY;
         target_subtype_ff <= RESET_SUBTYPE;
         report_total_ff   <= '0;
         direct_ff         <= 1'b0;
      end else begin
         target_company_ff <= target_company_in;
         target_subtype_ff <= target_subtype_in;
         report_total_ff   <= report_total_in;
         direct_ff         <= direct_in;
      end
   end

   // Report flags held for the result word.
   always_ff @(posedge clock) begin
      if (report_end) begin
         seen_ff <= flags.company_found;
         sub_ff  <= flags.subtype_ok;
      end
   end

   auc_scan u_scan (
      .clock          (clock),
      .reset          (reset),
      .byte_valid     (byte_valid),
      .data_byte      (req_data_byte),
      .byte_last      (req_byte_last),
      .target_company (target_company_ff),
      .target_subtype (target_subtype_ff),
      .flags          (flags)
   );

   auc_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .COUNT_WIDTH   (COUNT_WIDTH)
   ) u_table (
      .clock  (clock),
      .reset  (reset),
      .go     (table_go),
      .key    (req_sender_address),
      .status (tbl_status)
   );

   // Result word; table fields but unique_devices read zero on a subtype mismatch.
   assign rsp_strobe          = direct_ff || tbl_status.done;
   assign rsp_company_seen    = seen_ff;
   assign rsp_subtype_match   = sub_ff;
   assign rsp_new_device      = sub_ff && tbl_status.new_device;
   assign rsp_table_full      = sub_ff && tbl_status.table_full;
   assign rsp_entry_index     = sub_ff ? tbl_status.entry_index : '0;
   assign rsp_entry_packets   = sub_ff ? tbl_status.entry_packets : '0;
   assign rsp_unique_devices  = tbl_status.unique_devices;
   assign rsp_company_reports = report_total_ff;

endmodule

`default_nettype wire
